// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the alpha blend RTL.
// Depends on nothing; simulation builds get checks, synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define AOPB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define AOPB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AOPB_ASSERT(label, clk, rst_n, prop, msg)
`define AOPB_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/aopb_pkg.sv -----
// Shared types, codes and byte-order helpers for the alpha blend block.
// No dependencies; used by the interfaces and every module.
package aopb_pkg;

	localparam int unsigned SRC_PIX_W = 32;
	localparam int unsigned DST_PIX_W = 24;
	localparam int unsigned ALPHA_W   = 8;
	localparam int unsigned CH_W      = 8;
	localparam int unsigned NUM_CH    = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 4;

	localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'd0;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_FORMAT = 1'b0,
		CFG_DEST_FORMAT   = 1'b1
	} cfg_idx_t;

	// source byte orders
	typedef enum logic [3:0] {
		SRC_RGB24  = 4'd0,
		SRC_BGR24  = 4'd1,
		SRC_XRGB32 = 4'd2,
		SRC_XBGR32 = 4'd3,
		SRC_RGBX32 = 4'd4,
		SRC_BGRX32 = 4'd5,
		SRC_ARGB32 = 4'd6,
		SRC_ABGR32 = 4'd7,
		SRC_RGBA32 = 4'd8,
		SRC_BGRA32 = 4'd9
	} src_fmt_t;

	// destination byte orders
	typedef enum logic {
		DST_RGB24 = 1'b0,
		DST_BGR24 = 1'b1
	} dst_fmt_t;

	// per-lane operands, lane p is destination byte p
	typedef struct packed {
		logic [NUM_CH-1:0][CH_W-1:0] src_ch;
		logic [NUM_CH-1:0][CH_W-1:0] dst_ch;
		logic                        keep_dest;
		logic                        copy_src;
	} lane_ctl_t;

	// formats 10..15 mean nothing and leave the destination alone
	function automatic logic src_fmt_known(src_fmt_t sf);
		return (4'(sf) <= 4'(SRC_BGRA32));
	endfunction

	// source byte position feeding destination byte p
	function automatic logic [1:0] src_byte_pos(src_fmt_t sf, dst_fmt_t df, logic [1:0] p);
		logic [1:0] chan;
		logic [1:0] pos;
		// channel index (0 red, 1 green, 2 blue) that lives at dest byte p
		chan = (df == DST_BGR24) ? 2'(2'd2 - p) : p;
		unique case (sf)
			SRC_RGB24, SRC_RGBX32, SRC_RGBA32: pos = chan;
			SRC_BGR24, SRC_BGRX32, SRC_BGRA32: pos = 2'(2'd2 - chan);
			SRC_XRGB32, SRC_ARGB32:            pos = 2'(chan + 2'd1);
			SRC_XBGR32, SRC_ABGR32:            pos = 2'(2'd3 - chan);
			default:                           pos = chan;
		endcase
		return pos;
	endfunction

endpackage

// ----- rtl/aopb_in_if.sv -----
// Input channel: source pixel, plane alpha and current destination pixel.
// Depends on aopb_pkg for field widths.
interface aopb_in_if;
	logic                            valid;
	logic                            ready;
	logic [aopb_pkg::SRC_PIX_W-1:0]  source_pixel;
	logic [aopb_pkg::ALPHA_W-1:0]    alpha;
	logic [aopb_pkg::DST_PIX_W-1:0]  dest_pixel;

	modport source (output valid, source_pixel, alpha, dest_pixel, input ready);
	modport sink   (input valid, source_pixel, alpha, dest_pixel, output ready);
endinterface

// ----- rtl/aopb_out_if.sv -----
// Output channel: blended destination pixel.
// Depends on aopb_pkg for field widths.
interface aopb_out_if;
	logic                            valid;
	logic                            ready;
	logic [aopb_pkg::DST_PIX_W-1:0]  blended_pixel;

	modport source (output valid, blended_pixel, input ready);
	modport sink   (input valid, blended_pixel, output ready);
endinterface

// ----- rtl/aopb_unpack.sv -----
// Byte-order decode: lines source and destination channels up per destination byte.
// Depends on aopb_pkg.
module aopb_unpack (
	input  aopb_pkg::src_fmt_t                 src_fmt,
	input  aopb_pkg::dst_fmt_t                 dst_fmt,
	input  logic [aopb_pkg::SRC_PIX_W-1:0]     source_pixel,
	input  logic [aopb_pkg::ALPHA_W-1:0]       alpha,
	input  logic [aopb_pkg::DST_PIX_W-1:0]     dest_pixel,
	output aopb_pkg::lane_ctl_t                lane_ctl
);

	logic [3:0][aopb_pkg::CH_W-1:0]               src_bytes;
	logic [aopb_pkg::NUM_CH-1:0][aopb_pkg::CH_W-1:0] dst_bytes;

	assign src_bytes = source_pixel;
	assign dst_bytes = dest_pixel;

	// per destination byte pick the matching source byte
	always_comb begin
		for (int p = 0; p < aopb_pkg::NUM_CH; p++) begin
			lane_ctl.src_ch[p] = src_bytes[aopb_pkg::src_byte_pos(src_fmt, dst_fmt, 2'(p))];
			lane_ctl.dst_ch[p] = dst_bytes[p];
		end
		lane_ctl.keep_dest = !aopb_pkg::src_fmt_known(src_fmt) || (alpha == aopb_pkg::ALPHA_CLEAR);
		lane_ctl.copy_src  = (alpha == aopb_pkg::ALPHA_OPAQUE);
	end

endmodule

// ----- rtl/aopb_lane.sv -----
// One color channel of the over blend: floor((s*a + d*(255-a))/255).
// Depends on aopb_pkg.
module aopb_lane (
	input  logic [aopb_pkg::CH_W-1:0]    src_ch,
	input  logic [aopb_pkg::CH_W-1:0]    dst_ch,
	input  logic [aopb_pkg::ALPHA_W-1:0] alpha,
	input  logic                         keep_dest,
	input  logic                         copy_src,
	output logic [aopb_pkg::CH_W-1:0]    result
);

	logic [15:0] prod_s;
	logic [15:0] prod_d;
	logic [15:0] num;
	logic [15:0] quot_sum;

	// weighted sum, at most 255*255 so it fits in 16 bits
	assign prod_s = 16'(src_ch) * 16'(alpha);
	assign prod_d = 16'(dst_ch) * 16'(aopb_pkg::ALPHA_OPAQUE - alpha);
	assign num    = prod_s + prod_d;

	// exact floor(num/255) for every num up to 255*255: (num + num/256 + 1) / 256
	assign quot_sum = num + {8'd0, num[15:8]} + 16'd1;

	always_comb begin
		priority if (keep_dest) begin
			result = dst_ch;
		end else if (copy_src) begin
			result = src_ch;
		end else begin
			result = quot_sum[15:8];
		end
	end

endmodule

// ----- rtl/alpha_over_pixel_blend.sv -----
// Alpha "over" blend of one source pixel onto a 24-bit destination pixel.
// Pipeline: input register, then result register; both hold while the output stalls.
// Throughput: one item per cycle while blend.ready holds; the three channel blenders limit the cycle time.
// Reset (arst_n low, asynchronous): pipeline empties, both format registers return to 0.
// Depends on aopb_pkg, aopb_in_if, aopb_out_if, aopb_unpack, aopb_lane, assert_macros.svh.
`include "assert_macros.svh"

module alpha_over_pixel_blend (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [aopb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aopb_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	aopb_in_if.sink                          feed,
	aopb_out_if.source                       blend
);

	aopb_pkg::src_fmt_t source_format_q;
	aopb_pkg::dst_fmt_t dest_format_q;

	logic                            valid_s1;
	logic [aopb_pkg::SRC_PIX_W-1:0]  source_s1;
	logic [aopb_pkg::ALPHA_W-1:0]    alpha_s1;
	logic [aopb_pkg::DST_PIX_W-1:0]  dest_s1;

	logic                            valid_s2;
	logic [aopb_pkg::DST_PIX_W-1:0]  blended_s2;

	logic                            load_s2;
	logic                            load_s1;
	aopb_pkg::lane_ctl_t             lane_ctl;
	logic [aopb_pkg::NUM_CH-1:0][aopb_pkg::CH_W-1:0] lane_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= aopb_pkg::SRC_RGB24;
			dest_format_q   <= aopb_pkg::DST_RGB24;
		end else if (cfg_we) begin
			unique case (aopb_pkg::cfg_idx_t'(cfg_index))
				aopb_pkg::CFG_SOURCE_FORMAT: source_format_q <= aopb_pkg::src_fmt_t'(cfg_wdata);
				aopb_pkg::CFG_DEST_FORMAT:   dest_format_q   <= aopb_pkg::dst_fmt_t'(cfg_wdata[0]);
				default: ;
			endcase
		end
	end

	// handshake: each stage moves when the one after it is free or draining
	assign load_s2    = !valid_s2 || blend.ready;
	assign load_s1    = !valid_s1 || load_s2;
	assign feed.ready = load_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= feed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && feed.valid) begin
			source_s1 <= feed.source_pixel;
			alpha_s1  <= feed.alpha;
			dest_s1   <= feed.dest_pixel;
		end
	end

	// byte-order decode
	aopb_unpack u_unpack (
		.src_fmt      (source_format_q),
		.dst_fmt      (dest_format_q),
		.source_pixel (source_s1),
		.alpha        (alpha_s1),
		.dest_pixel   (dest_s1),
		.lane_ctl     (lane_ctl)
	);

	// three channel blenders
	for (genvar p = 0; p < aopb_pkg::NUM_CH; p++) begin : g_lane
		aopb_lane u_lane (
			.src_ch    (lane_ctl.src_ch[p]),
			.dst_ch    (lane_ctl.dst_ch[p]),
			.alpha     (alpha_s1),
			.keep_dest (lane_ctl.keep_dest),
			.copy_src  (lane_ctl.copy_src),
			.result    (lane_res[p])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			blended_s2 <= lane_res;
		end
	end

	assign blend.valid         = valid_s2;
	assign blend.blended_pixel = blended_s2;

	// checks
	`AOPB_ASSERT(a_accept_fills_s1, clk, arst_n, (feed.valid && feed.ready) |=> valid_s1, "accepted item missing from input stage")
	`AOPB_ASSERT(a_s1_moves_to_s2, clk, arst_n, (valid_s1 && load_s2) |=> valid_s2, "item lost between stages")
	`AOPB_ASSERT_NEVER(a_no_overwrite, clk, arst_n, feed.ready && valid_s1 && !load_s2, "input stage overwritten while stalled")
	`AOPB_ASSERT(a_clear_keeps_dest, clk, arst_n, (valid_s1 && load_s2 && alpha_s1 == aopb_pkg::ALPHA_CLEAR) |=> (blend.blended_pixel == $past(dest_s1)), "zero alpha changed destination")

endmodule
